/* hw/rtl/rvst_pkg.sv */
// rvst_pkg: command and result item types and codes for the removable volume slot table.
// No dependencies; imported by removable_volume_slot_table_unit.
`default_nettype none

package rvst_pkg;

  // command codes
  localparam logic [2:0] FN_REGISTER   = 3'd0;
  localparam logic [2:0] FN_UNREGISTER = 3'd1;
  localparam logic [2:0] FN_MARK_DIRTY = 3'd2;
  localparam logic [2:0] FN_ACQUIRE    = 3'd3;
  localparam logic [2:0] FN_RELEASE    = 3'd4;
  localparam logic [2:0] FN_EJECT      = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;

  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [4:0]  device_id;
    logic [31:0] byte_count;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  assigned_id;
    logic [31:0] flushed_bytes;
  } result_t;

  // one slot entry as kept in the entry memory
  typedef struct packed {
    logic        dirty;
    logic [31:0] pending;
    logic [15:0] refs;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/removable_volume_slot_table_unit.sv */
// removable_volume_slot_table_unit: slot table with read-modify-write of one entry per item.
// Depends on rvst_pkg (item types, command and status codes).
//
//   channel   ports                 handshake
//   command   start, busy, cmd      taken on a clock edge with start high and busy low
//   result    done, result          done high for one cycle, one result per command
//
// Each item: the accept edge reads the entry memory (one port), the
// next cycle runs the shared adder and writes the entry back, then the result shows
// for one cycle while a new item may already be accepted.
// rst (synchronous) clears the in-use flags; entries are rewritten when a slot is
// registered, so the memory needs no clearing. The receiver cannot stall.
`default_nettype none

module removable_volume_slot_table_unit #(
  parameter int SLOTS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire rvst_pkg::cmd_t  cmd,
  output logic                 done,
  output rvst_pkg::result_t    result
);
  import rvst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state;
  logic [SLOTS-1:0]   slot_used;
  entry_t             mem [SLOTS];
  entry_t             rd_data;

  logic [2:0]         func_q;
  logic [31:0]        bytes_q;
  logic [IDX_W-1:0]   idx_q;
  logic               id_ok_q;
  logic               free_found_q;

  logic               accept;
  logic               id_ok;
  logic [4:0]         id_m1;
  logic [IDX_W-1:0]   id_idx;
  logic [IDX_W-1:0]   free_idx;
  logic               free_found;
  logic [IDX_W-1:0]   rd_idx;

  logic [31:0]        op_a;
  logic [31:0]        op_b;
  logic [31:0]        sum;
  logic               wr_en;
  entry_t             wr_data;
  logic               used_set;
  logic               used_clr;
  result_t            res_next;

  assign busy   = (state == S_EXEC);
  assign accept = start && !busy;

  assign id_ok  = (cmd.device_id != 5'd0) && ({27'd0, cmd.device_id} <= 32'(SLOTS));
  assign id_m1  = cmd.device_id - 5'd1;
  assign id_idx = id_ok ? id_m1[IDX_W-1:0] : '0;

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign rd_idx = (cmd.func == FN_REGISTER) ? free_idx : id_idx;

  // shared adder: pending + bytes, refs + 1, refs - 1
  always_comb begin
    unique case (func_q)
      FN_MARK_DIRTY: begin
        op_a = rd_data.pending;
        op_b = bytes_q;
      end
      FN_RELEASE: begin
        op_a = {16'd0, rd_data.refs};
        op_b = 32'hFFFF_FFFF;
      end
      default: begin
        op_a = {16'd0, rd_data.refs};
        op_b = 32'd1;
      end
    endcase
  end
  assign sum = op_a + op_b;

  always_comb begin
    res_next = '{status: ST_OK, assigned_id: 5'd0, flushed_bytes: 32'd0};
    wr_en    = 1'b0;
    wr_data  = rd_data;
    used_set = 1'b0;
    used_clr = 1'b0;
    if (func_q == FN_REGISTER) begin
      if (free_found_q) begin
        wr_en                = 1'b1;
        wr_data              = '0;
        used_set             = 1'b1;
        res_next.assigned_id = 5'(idx_q) + 5'd1;
      end else begin
        res_next.status = ST_FULL;
      end
    end else if (func_q > FN_EJECT || !id_ok_q) begin
      res_next.status = ST_INVALID;
    end else if (!slot_used[idx_q]) begin
      res_next.status = ST_NOT_FOUND;
    end else begin
      unique case (func_q)
        FN_UNREGISTER: begin
          if (rd_data.refs != 16'd0) begin
            res_next.status = ST_BUSY;
          end else begin
            wr_en    = 1'b1;
            wr_data  = '0;
            used_clr = 1'b1;
          end
        end
        FN_MARK_DIRTY: begin
          wr_en           = 1'b1;
          wr_data.dirty   = 1'b1;
          wr_data.pending = sum;
        end
        FN_ACQUIRE: begin
          wr_en        = (rd_data.refs != REFS_MAX);
          wr_data.refs = sum[15:0];
        end
        FN_RELEASE: begin
          wr_en        = (rd_data.refs != 16'd0);
          wr_data.refs = sum[15:0];
        end
        default: begin
          if (rd_data.refs != 16'd0) begin
            res_next.status = ST_BUSY;
          end else begin
            res_next.flushed_bytes = rd_data.pending;
            wr_en                  = 1'b1;
            wr_data.pending        = 32'd0;
            wr_data.dirty          = 1'b0;
          end
        end
      endcase
    end
  end

  // entry memory: read at accept, written back in the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[rd_idx];
    end
    if (state == S_EXEC && wr_en) begin
      mem[idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q       <= cmd.func;
      bytes_q      <= cmd.byte_count;
      idx_q        <= rd_idx;
      id_ok_q      <= id_ok;
      free_found_q <= free_found;
    end
    if (state == S_EXEC) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      slot_used <= '0;
    end else begin
      done <= (state == S_EXEC);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          if (used_set) begin
            slot_used[idx_q] <= 1'b1;
          end else if (used_clr) begin
            slot_used[idx_q] <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
